>>> design/admittance_control_six_axis_top_assert.svh
// Assertion macros for the six-axis admittance block.
// Used by the port checker; no other dependencies.
`ifndef ADMITTANCE_CONTROL_SIX_AXIS_TOP_ASSERT_SVH
`define ADMITTANCE_CONTROL_SIX_AXIS_TOP_ASSERT_SVH
// Generic clocked check, disabled while in reset.
`define ACS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// A flag that once set stays set.
`define ACS_ASSERT_STICKY(lbl, sig, msg) \
  `ACS_ASSERT(lbl, (sig) |=> (sig), msg)
`endif

>>> design/acs_pkg.sv
// Shared widths, register indexes and lane result type for the admittance block.
// No dependencies.
package acs_pkg;

  localparam int FORCE_W = 32;
  localparam int TORQUE_W = 29;
  localparam int STEP_W = 27;
  localparam int VEL_W = 32;
  localparam int MASS_W = 31;
  localparam int TS_W = 25;
  localparam int TDB_W = 28;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;
  localparam int LSTEP_W = 34;
  localparam int LANES = 6;

  localparam logic [30:0] RST_LIN_MASS = 31'd167772;
  localparam logic [30:0] RST_LIN_DAMP = 31'd16777216;
  localparam logic [30:0] RST_ANG_MASS = 31'd503316;
  localparam logic [30:0] RST_ANG_DAMP = 31'd16777216;
  localparam logic [24:0] RST_TSTEP = 25'd167772;
  localparam logic [30:0] RST_FORCE_DB = 31'd16777216;
  localparam logic [27:0] RST_TORQUE_DB = 28'd838861;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LIN_MASS  = 3'd0,
    CFG_LIN_DAMP  = 3'd1,
    CFG_ANG_MASS  = 3'd2,
    CFG_ANG_DAMP  = 3'd3,
    CFG_TSTEP     = 3'd4,
    CFG_FORCE_DB  = 3'd5,
    CFG_TORQUE_DB = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                       done;
    logic signed [VEL_W-1:0]    nv;
    logic signed [LSTEP_W-1:0]  step;
  } lane_res_t;

endpackage

>>> design/acs_lane.sv
// One axis of the mass-damper admittance step with a radix-4 restoring divider.
// Depends on acs_pkg.
module acs_lane #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [acs_pkg::VEL_W-1:0]    f_i,
  input  logic signed [acs_pkg::VEL_W-1:0]    v_i,
  input  logic [acs_pkg::MASS_W-1:0]          mass_i,
  input  logic [acs_pkg::MASS_W-1:0]          damp_i,
  input  logic [acs_pkg::MASS_W-1:0]          dband_i,
  input  logic [acs_pkg::TS_W-1:0]            tstep_i,
  output acs_pkg::lane_res_t                  res_o
);

  typedef enum logic [7:0] {
    L_IDLE  = 8'b0000_0001,
    L_DTERM = 8'b0000_0010,
    L_NUM   = 8'b0000_0100,
    L_DIVIN = 8'b0000_1000,
    L_DIV   = 8'b0001_0000,
    L_ALO   = 8'b0010_0000,
    L_AHI   = 8'b0100_0000,
    L_FIN   = 8'b1000_0000
  } lstate_e;

  localparam int DIV_STEPS = 29;
  localparam logic signed [59:0] ONE_Q = 60'sd1 <<< FRAC_BITS;

  lstate_e state_q, state_d;
  logic done_q;
  logic [4:0] cnt_q;
  logic signed [31:0] f_q, v_q;
  logic [31:0] va_q;
  logic act_q, num_neg_q;
  logic [30:0] mm_q;
  logic [62:0] prod_q;
  logic [32:0] na_q, vterm_q;
  logic [57:0] div_n_q, quo_q;
  logic [31:0] rem_q;
  logic [53:0] plo_q, phi_q;
  logic signed [31:0] nv_q;
  logic signed [33:0] step_q;

  logic [32:0] f_ext, f_mag;
  logic [31:0] v_mag;
  logic [32:0] dterm;
  logic [34:0] sdterm, num35, num_abs;
  logic [56:0] vprod;
  logic [57:0] nprod;
  logic [31:0] r_n;
  logic [57:0] n_n, q_n;
  logic [32:0] t_n;
  logic [82:0] total, sh;
  logic [31:0] aterm;
  logic [33:0] sv, sa, step_n;
  logic [59:0] dvel, sum60;
  logic signed [31:0] nv_n;

  always_comb begin
    f_ext = {f_i[31], f_i};
    f_mag = f_i[31] ? (~f_ext + 33'd1) : f_ext;
    v_mag = v_i[31] ? (~v_i + 32'd1) : v_i;
    dterm = 33'(prod_q >> FRAC_BITS);
    sdterm = v_q[31] ? (~{2'b00, dterm} + 35'd1) : {2'b00, dterm};
    num35 = {{3{f_q[31]}}, f_q} - sdterm;
    num_abs = num35[34] ? (~num35 + 35'd1) : num35;
    vprod = va_q * tstep_i;
    nprod = na_q * tstep_i;
    // two quotient bits a cycle
    r_n = rem_q;
    n_n = div_n_q;
    q_n = quo_q;
    t_n = '0;
    for (int k = 0; k < 2; k++) begin
      t_n = {r_n, n_n[57]};
      if (t_n >= {2'b00, mm_q}) begin
        r_n = 32'(t_n - {2'b00, mm_q});
        q_n = {q_n[56:0], 1'b1};
      end else begin
        r_n = t_n[31:0];
        q_n = {q_n[56:0], 1'b0};
      end
      n_n = {n_n[56:0], 1'b0};
    end
    // capped acceleration term, cap lies far beyond output saturation
    total = {phi_q, 29'd0} + {29'd0, plo_q};
    sh = total >> (FRAC_BITS + 1);
    aterm = (|sh[82:31]) ? 32'h8000_0000 : sh[31:0];
    sv = v_q[31] ? (~{1'b0, vterm_q} + 34'd1) : {1'b0, vterm_q};
    sa = num_neg_q ? (~{2'b00, aterm} + 34'd1) : {2'b00, aterm};
    step_n = sv + sa;
    dvel = num_neg_q ? (~{2'b00, quo_q} + 60'd1) : {2'b00, quo_q};
    sum60 = {{28{v_q[31]}}, v_q} + dvel;
    if ($signed(sum60) > ONE_Q) begin
      nv_n = 32'(ONE_Q);
    end else if ($signed(sum60) < -ONE_Q) begin
      nv_n = 32'(-ONE_Q);
    end else begin
      nv_n = sum60[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:  if (start_i) state_d = L_DTERM;
      L_DTERM: state_d = L_NUM;
      L_NUM:   state_d = L_DIVIN;
      L_DIVIN: state_d = L_DIV;
      L_DIV:   if (cnt_q == 5'(DIV_STEPS - 1)) state_d = L_ALO;
      L_ALO:   state_d = L_AHI;
      L_AHI:   state_d = L_FIN;
      L_FIN:   state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == L_IDLE) done_q <= 1'b0;
      else if (state_q == L_FIN) done_q <= 1'b1;
      if (state_q == L_DIV) cnt_q <= cnt_q + 5'd1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      L_IDLE: begin
        f_q <= f_i;
        v_q <= v_i;
        va_q <= v_mag;
        act_q <= f_mag > {2'b00, dband_i};
        mm_q <= (mass_i == '0) ? 31'd1 : mass_i;
      end
      L_DTERM: prod_q <= damp_i * va_q;
      L_NUM: begin
        num_neg_q <= num35[34];
        na_q <= num_abs[32:0];
        vterm_q <= 33'(vprod >> FRAC_BITS);
      end
      L_DIVIN: begin
        div_n_q <= nprod;
        rem_q <= '0;
        quo_q <= '0;
      end
      L_DIV: begin
        div_n_q <= n_n;
        rem_q <= r_n;
        quo_q <= q_n;
      end
      L_ALO: plo_q <= quo_q[28:0] * tstep_i;
      L_AHI: phi_q <= quo_q[57:29] * tstep_i;
      L_FIN: begin
        nv_q <= act_q ? nv_n : '0;
        step_q <= act_q ? $signed(step_n) : '0;
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.nv = nv_q;
  assign res_o.step = step_q;

endmodule

>>> design/admittance_control_six_axis_top.sv
// Top level of the six-axis admittance controller: config registers, six lanes, merge.
// Depends on acs_pkg and acs_lane.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | in        | in_valid_i / in_ready_o   | force_x..z_i, torque_x..z_i
//  out     | out       | out_valid_o / out_ready_i | step_x..z_o, turn_x..z_o, faults
//  cfg     | in        | cfg_we_i (no wait)        | cfg_addr_i, cfg_wdata_i
//
// Each item runs through these steps from input beat to result: each lane forms
// the damping product and numerator, runs its divider (two quotient bits a
// cycle over a 58-bit dividend), then the step products, and a merge follows.
// Reset clears velocities, faults and loads the default registers. A held
// result does not stop the next input beat; only a finished merge waits for
// the output register to be free.
module admittance_control_six_axis_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acs_pkg::CFG_AW-1:0]         cfg_addr_i,
  input  logic [acs_pkg::CFG_DW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [acs_pkg::FORCE_W-1:0] force_x_i,
  input  logic signed [acs_pkg::FORCE_W-1:0] force_y_i,
  input  logic signed [acs_pkg::FORCE_W-1:0] force_z_i,
  input  logic signed [acs_pkg::TORQUE_W-1:0] torque_x_i,
  input  logic signed [acs_pkg::TORQUE_W-1:0] torque_y_i,
  input  logic signed [acs_pkg::TORQUE_W-1:0] torque_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [acs_pkg::STEP_W-1:0]  step_x_o,
  output logic signed [acs_pkg::STEP_W-1:0]  step_y_o,
  output logic signed [acs_pkg::STEP_W-1:0]  step_z_o,
  output logic signed [acs_pkg::STEP_W-1:0]  turn_x_o,
  output logic signed [acs_pkg::STEP_W-1:0]  turn_y_o,
  output logic signed [acs_pkg::STEP_W-1:0]  turn_z_o,
  output logic                               linear_fault_o,
  output logic                               angular_fault_o
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_BUSY = 2'b10
  } tstate_e;

  localparam int LANES = acs_pkg::LANES;
  // fault limits 0.3 and 0.2, rounded to nearest LSB
  localparam logic [33:0] LIN_LIMIT = 34'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [33:0] ANG_LIMIT = 34'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [33:0] STEP_SAT = 34'sd2 <<< FRAC_BITS;

  tstate_e state_q, state_d;

  // configuration registers
  logic [30:0] lin_mass_q, lin_damp_q, ang_mass_q, ang_damp_q, force_db_q;
  logic [24:0] tstep_q;
  logic [27:0] torque_db_q;

  logic signed [31:0] vel_q [LANES];
  logic halt_lin_q, halt_ang_q;
  logic out_valid_q;
  logic signed [26:0] out_q [LANES];

  acs_pkg::lane_res_t res [LANES];
  logic signed [31:0] lane_f [LANES];
  logic [LANES-1:0] done_vec;
  logic accept, merge;
  logic over_lin, over_ang;
  logic [33:0] st_mag [LANES];
  logic signed [26:0] sat_st [LANES];

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == T_IDLE);

  assign lane_f[0] = force_x_i;
  assign lane_f[1] = force_y_i;
  assign lane_f[2] = force_z_i;
  assign lane_f[3] = 32'(torque_x_i);
  assign lane_f[4] = 32'(torque_y_i);
  assign lane_f[5] = 32'(torque_z_i);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    localparam bit ANG = (g >= 3);
    acs_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (accept),
      .f_i     (lane_f[g]),
      .v_i     (vel_q[g]),
      .mass_i  (ANG ? ang_mass_q : lin_mass_q),
      .damp_i  (ANG ? ang_damp_q : lin_damp_q),
      .dband_i (ANG ? {3'b000, torque_db_q} : force_db_q),
      .tstep_i (tstep_q),
      .res_o   (res[g])
    );
    assign done_vec[g] = res[g].done;
  end

  // merge: fault decision per group and output saturation
  always_comb begin
    over_lin = 1'b0;
    over_ang = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      st_mag[i] = res[i].step[33] ? (~res[i].step + 34'd1) : res[i].step;
      if (res[i].step > STEP_SAT) sat_st[i] = STEP_SAT[26:0];
      else if (res[i].step < -STEP_SAT) sat_st[i] = 27'(-STEP_SAT);
      else sat_st[i] = res[i].step[26:0];
      if (i < 3) begin
        if (st_mag[i] > LIN_LIMIT) over_lin = 1'b1;
      end else begin
        if (st_mag[i] > ANG_LIMIT) over_ang = 1'b1;
      end
    end
  end

  assign merge = (state_q == T_BUSY) && (&done_vec) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (accept) state_d = T_BUSY;
      T_BUSY:  if (merge) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      lin_mass_q <= acs_pkg::RST_LIN_MASS;
      lin_damp_q <= acs_pkg::RST_LIN_DAMP;
      ang_mass_q <= acs_pkg::RST_ANG_MASS;
      ang_damp_q <= acs_pkg::RST_ANG_DAMP;
      tstep_q <= acs_pkg::RST_TSTEP;
      force_db_q <= acs_pkg::RST_FORCE_DB;
      torque_db_q <= acs_pkg::RST_TORQUE_DB;
      for (int i = 0; i < LANES; i++) vel_q[i] <= '0;
      halt_lin_q <= 1'b0;
      halt_ang_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          acs_pkg::CFG_LIN_MASS:  lin_mass_q <= cfg_wdata_i;
          acs_pkg::CFG_LIN_DAMP:  lin_damp_q <= cfg_wdata_i;
          acs_pkg::CFG_ANG_MASS:  ang_mass_q <= cfg_wdata_i;
          acs_pkg::CFG_ANG_DAMP:  ang_damp_q <= cfg_wdata_i;
          acs_pkg::CFG_TSTEP:     tstep_q <= cfg_wdata_i[24:0];
          acs_pkg::CFG_FORCE_DB:  force_db_q <= cfg_wdata_i;
          acs_pkg::CFG_TORQUE_DB: torque_db_q <= cfg_wdata_i[27:0];
          default: ;
        endcase
      end
      if (merge) begin
        out_valid_q <= 1'b1;
        // velocities move only for a group that neither was halted nor faults now
        for (int i = 0; i < 3; i++) begin
          if (!halt_lin_q && !over_lin) vel_q[i] <= res[i].nv;
          if (!halt_ang_q && !over_ang) vel_q[i+3] <= res[i+3].nv;
        end
        if (over_lin) halt_lin_q <= 1'b1;
        if (over_ang) halt_ang_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register; halted groups report zero steps
  always_ff @(posedge clk_i) begin
    if (merge) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= halt_lin_q ? '0 : sat_st[i];
        out_q[i+3] <= halt_ang_q ? '0 : sat_st[i+3];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign step_x_o = out_q[0];
  assign step_y_o = out_q[1];
  assign step_z_o = out_q[2];
  assign turn_x_o = out_q[3];
  assign turn_y_o = out_q[4];
  assign turn_z_o = out_q[5];
  assign linear_fault_o = halt_lin_q;
  assign angular_fault_o = halt_ang_q;

endmodule

>>> design/acs_checker.sv
// Port-level checks for the admittance block, bound to the top level.
// Depends on admittance_control_six_axis_top_assert.svh.
`include "admittance_control_six_axis_top_assert.svh"

module acs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [26:0] step_x_o,
  input logic linear_fault_o,
  input logic angular_fault_o
);

  `ACS_ASSERT_STICKY(a_lin_fault_sticky, linear_fault_o, "linear fault dropped")
  `ACS_ASSERT_STICKY(a_ang_fault_sticky, angular_fault_o, "angular fault dropped")
  `ACS_ASSERT(a_busy_after_beat, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after beat")
  `ACS_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(step_x_o)), "result not held")

endmodule

bind admittance_control_six_axis_top acs_checker u_acs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .step_x_o       (step_x_o),
  .linear_fault_o (linear_fault_o),
  .angular_fault_o(angular_fault_o)
);
